### rtl/core/sorted_list_intersection_macros.svh
// ----------------------------------------------------------------------------
// Sorted list intersection assertion macros
// Concurrent assertion wrappers used by the sorted list intersection controller.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INTERSECTION_MACROS_SVH
`define SORTED_LIST_INTERSECTION_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SLI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SLI_ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define SLI_ASSERT(lbl, prop, msg)
`define SLI_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

### rtl/core/sli_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list intersection package
// Operation codes and controller state type.
// ----------------------------------------------------------------------------
package sli_pkg;

   typedef enum logic [1:0] {
      OP_LOAD_A = 2'd0,
      OP_LOAD_B = 2'd1,
      OP_RUN    = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_COMPARE,
      ST_FINISH
   } state_type;

endpackage

### rtl/core/sli_list_mem.sv
// ----------------------------------------------------------------------------
// Sorted list intersection list memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module sli_list_mem #(
   parameter int DEPTH   = 32,
   parameter int WIDTH   = 32,
   parameter int ADDR_W  = 5
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic signed [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0]        rd_addr,
   output logic signed [WIDTH-1:0]  rd_data
);

   logic signed [WIDTH-1:0] mem [DEPTH];
   logic signed [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/sli_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted list intersection controller
// Load counters, two-pointer walk, pending match and result register.
// ----------------------------------------------------------------------------
`include "sorted_list_intersection_macros.svh"

module sli_ctrl
   import sli_pkg::*;
#(
   parameter int MAX_LEN = 32,
   parameter int WIDTH   = 32,
   parameter int ADDR_W  = 5,
   parameter int CNT_W   = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_op,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [WIDTH-1:0]  rsp_match_value,
   output logic                     rsp_last,
   output logic                     rsp_empty_res,
   output logic                     wr_en_a,
   output logic                     wr_en_b,
   output logic [ADDR_W-1:0]        wr_addr_a,
   output logic [ADDR_W-1:0]        wr_addr_b,
   output logic [ADDR_W-1:0]        rd_addr_a,
   output logic [ADDR_W-1:0]        rd_addr_b,
   input  logic signed [WIDTH-1:0]  rd_data_a,
   input  logic signed [WIDTH-1:0]  rd_data_b
);

   localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_LEN);

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_a_ff, count_a_in;
   logic [CNT_W-1:0]        count_b_ff, count_b_in;
   logic [CNT_W-1:0]        ptr_a_ff, ptr_a_in;
   logic [CNT_W-1:0]        ptr_b_ff, ptr_b_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic signed [WIDTH-1:0] pend_value_ff, pend_value_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic                    accept;
   logic                    out_free;
   op_type                  op;

   assign op       = op_type'(req_op);
   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_a_ff    <= '0;
         count_b_ff    <= '0;
         ptr_a_ff      <= '0;
         ptr_b_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_a_ff    <= count_a_in;
         count_b_ff    <= count_b_in;
         ptr_a_ff      <= ptr_a_in;
         ptr_b_ff      <= ptr_b_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_value_ff <= pend_value_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_a_in    = count_a_ff;
      count_b_in    = count_b_ff;
      ptr_a_in      = ptr_a_ff;
      ptr_b_in      = ptr_b_ff;
      pend_valid_in = pend_valid_ff;
      pend_value_in = pend_value_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;
      wr_en_a       = 1'b0;
      wr_en_b       = 1'b0;
      req_stall     = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op)
                  OP_LOAD_A: begin
                     if (count_a_ff < FULL) begin
                        wr_en_a    = 1'b1;
                        count_a_in = count_a_ff + CNT_W'(1);
                     end
                  end
                  OP_LOAD_B: begin
                     if (count_b_ff < FULL) begin
                        wr_en_b    = 1'b1;
                        count_b_in = count_b_ff + CNT_W'(1);
                     end
                  end
                  OP_RUN: begin
                     ptr_a_in      = '0;
                     ptr_b_in      = '0;
                     pend_valid_in = 1'b0;
                     state_in      = ST_FETCH;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH: begin
            if (ptr_a_ff >= count_a_ff || ptr_b_ff >= count_b_ff) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (rd_data_a < rd_data_b) begin
               ptr_a_in = ptr_a_ff + CNT_W'(1);
               state_in = ST_FETCH;
            end else if (rd_data_b < rd_data_a) begin
               ptr_b_in = ptr_b_ff + CNT_W'(1);
               state_in = ST_FETCH;
            end else if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = pend_value_ff;
                  rsp_last_in  = 1'b0;
                  rsp_empty_in = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_value_in = rd_data_a;
               ptr_a_in      = ptr_a_ff + CNT_W'(1);
               ptr_b_in      = ptr_b_ff + CNT_W'(1);
               state_in      = ST_FETCH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = pend_valid_ff ? pend_value_ff : '0;
               rsp_last_in   = 1'b1;
               rsp_empty_in  = !pend_valid_ff;
               pend_valid_in = 1'b0;
               count_a_in    = '0;
               count_b_in    = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign wr_addr_a       = count_a_ff[ADDR_W-1:0];
   assign wr_addr_b       = count_b_ff[ADDR_W-1:0];
   assign rd_addr_a       = ptr_a_ff[ADDR_W-1:0];
   assign rd_addr_b       = ptr_b_ff[ADDR_W-1:0];
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_value = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_empty_res   = rsp_empty_ff;

   `SLI_ASSERT_NEVER(a_count_a_bound, count_a_ff > FULL || count_b_ff > FULL, "count overflow")
   `SLI_ASSERT(a_cmp_in_range,
      state_ff == ST_COMPARE |-> ptr_a_ff < count_a_ff && ptr_b_ff < count_b_ff,
      "pointer out of range")
   `SLI_ASSERT(a_idle_no_pend, state_ff == ST_IDLE |-> !pend_valid_ff, "pending match while idle")
   `SLI_ASSERT(a_finish_clears,
      state_ff == ST_FINISH && out_free |=> state_ff == ST_IDLE && count_a_ff == '0
         && count_b_ff == '0 && rsp_valid_ff && rsp_last_ff,
      "run did not close")

endmodule

### rtl/core/sorted_list_intersection.sv
// ----------------------------------------------------------------------------
// Sorted list intersection
// Two list memories walked by a two-pointer controller.
// ----------------------------------------------------------------------------
//  Channel  Direction  Ports                                     Item
//  req      in         req_valid req_stall req_op req_value      load or run
//  rsp      out        rsp_valid rsp_stall rsp_match_value ...   one match
//
// A load item is written while the controller is idle. Each pointer step of a
// run passes through the fetch and compare states, set by the registered read
// of the list memories, and the run closes in the finish state. Results leave
// through an output register. Reset clears the counts and control state; the
// memories need no clearing. A stalled output holds the walk on the next match.
// ----------------------------------------------------------------------------
module sorted_list_intersection
   import sli_pkg::*;
#(
   parameter int MAX_LEN     = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_op,
   input  logic signed [VALUE_WIDTH-1:0]  req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [VALUE_WIDTH-1:0]  rsp_match_value,
   output logic                           rsp_last,
   output logic                           rsp_empty_res
);

   localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CNT_W  = $clog2(MAX_LEN + 1);

   logic                          wr_en_a, wr_en_b;
   logic [ADDR_W-1:0]             wr_addr_a, wr_addr_b;
   logic [ADDR_W-1:0]             rd_addr_a, rd_addr_b;
   logic signed [VALUE_WIDTH-1:0] rd_data_a, rd_data_b;

   sli_list_mem #(
      .DEPTH  (MAX_LEN),
      .WIDTH  (VALUE_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_mem_a (
      .clock   (clock),
      .wr_en   (wr_en_a),
      .wr_addr (wr_addr_a),
      .wr_data (req_value),
      .rd_addr (rd_addr_a),
      .rd_data (rd_data_a)
   );

   sli_list_mem #(
      .DEPTH  (MAX_LEN),
      .WIDTH  (VALUE_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_mem_b (
      .clock   (clock),
      .wr_en   (wr_en_b),
      .wr_addr (wr_addr_b),
      .wr_data (req_value),
      .rd_addr (rd_addr_b),
      .rd_data (rd_data_b)
   );

   sli_ctrl #(
      .MAX_LEN (MAX_LEN),
      .WIDTH   (VALUE_WIDTH),
      .ADDR_W  (ADDR_W),
      .CNT_W   (CNT_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_match_value (rsp_match_value),
      .rsp_last        (rsp_last),
      .rsp_empty_res   (rsp_empty_res),
      .wr_en_a         (wr_en_a),
      .wr_en_b         (wr_en_b),
      .wr_addr_a       (wr_addr_a),
      .wr_addr_b       (wr_addr_b),
      .rd_addr_a       (rd_addr_a),
      .rd_addr_b       (rd_addr_b),
      .rd_data_a       (rd_data_a),
      .rd_data_b       (rd_data_b)
   );

endmodule

### tb/sv/sorted_list_intersection_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list intersection testbench
// Fills both lists through the request channel and starts runs. A scoreboard
// does the same two-pointer walk and checks each match in order. The stimulus
// has directed extremes, sorted lists with shared values, unsorted and
// overflowing lists, and random noise. Both channels idle in random bursts,
// except near the end.
// ----------------------------------------------------------------------------
module sorted_list_intersection_tb
   import sli_pkg::*;
();

   localparam int LIST_DEPTH    = 32;
   localparam int VALUE_BITS    = 32;
   localparam int RANDOM_ITEMS  = 120;
   localparam int QUIET_ITEMS   = 30;
   localparam int SETTLE_CYCLES = 4 * LIST_DEPTH + 16;
   localparam int DRAIN_LIMIT   = 20000;

   typedef logic signed [VALUE_BITS-1:0] value_type;

   typedef struct packed {
      value_type match_value;
      logic      last;
      logic      empty_res;
   } match_type;

   localparam value_type VALUE_MIN = {1'b1, {(VALUE_BITS - 1){1'b0}}};
   localparam value_type VALUE_MAX = {1'b0, {(VALUE_BITS - 1){1'b1}}};

   class intersection_scoreboard;
      value_type  list_a [LIST_DEPTH];
      value_type  list_b [LIST_DEPTH];
      logic [5:0] len_a;
      logic [5:0] len_b;
      match_type  match_queue [$];
      int         errors;
      int         runs;
      int         empty_runs;
      int         checked;
      int         longest;

      function new();
         len_a = '0;
         len_b = '0;
         errors = 0;
         runs = 0;
         empty_runs = 0;
         checked = 0;
         longest = 0;
      endfunction

      function void note_item(op_type op, value_type value);
         int        i;
         int        j;
         int        found;
         match_type m;
         case (op)
            OP_LOAD_A: begin
               if (len_a < LIST_DEPTH) begin
                  list_a[len_a] = value;
                  len_a++;
               end
            end
            OP_LOAD_B: begin
               if (len_b < LIST_DEPTH) begin
                  list_b[len_b] = value;
                  len_b++;
               end
            end
            OP_RUN: begin
               i = 0;
               j = 0;
               found = 0;
               while (i < len_a && j < len_b) begin
                  if (list_a[i] < list_b[j]) begin
                     i++;
                  end else if (list_b[j] < list_a[i]) begin
                     j++;
                  end else begin
                     m.match_value = list_a[i];
                     m.last = 1'b0;
                     m.empty_res = 1'b0;
                     match_queue = {match_queue, m};
                     found++;
                     i++;
                     j++;
                  end
               end
               if (found == 0) begin
                  m.match_value = '0;
                  m.last = 1'b1;
                  m.empty_res = 1'b1;
                  match_queue = {match_queue, m};
                  empty_runs++;
               end else begin
                  m = match_queue.pop_back();
                  m.last = 1'b1;
                  match_queue = {match_queue, m};
               end
               if (found > longest) longest = found;
               runs++;
               len_a = '0;
               len_b = '0;
            end
            default: begin
            end
         endcase
      endfunction

      task report_mismatch(string what);
         $display("[%0t] mismatch: %s", $time, what);
         errors++;
      endtask

      task check_result(value_type value, logic last, logic empty_res);
         match_type want;
         if (match_queue.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no match pending", value));
            return;
         end
         want = match_queue.pop_front();
         checked++;
         if (value !== want.match_value)
            report_mismatch($sformatf("match_value %0d, wanted %0d", value, want.match_value));
         if (last !== want.last)
            report_mismatch($sformatf("last %b, wanted %b", last, want.last));
         if (empty_res !== want.empty_res)
            report_mismatch($sformatf("empty_res %b, wanted %b", empty_res, want.empty_res));
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_op = OP_NONE;
   value_type  req_value = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   value_type  rsp_match_value;
   logic       rsp_last;
   logic       rsp_empty_res;

   intersection_scoreboard sb;
   bit idle_on = 1'b1;
   int items_sent = 0;

   sorted_list_intersection #(
      .MAX_LEN(LIST_DEPTH),
      .VALUE_WIDTH(VALUE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_match_value(rsp_match_value),
      .rsp_last(rsp_last),
      .rsp_empty_res(rsp_empty_res)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_result(rsp_match_value, rsp_last, rsp_empty_res);
   end

   task automatic send_item(op_type op, value_type value);
      int gap;
      gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_value <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_item(op, value);
      if (op != OP_NONE) items_sent++;
   endtask

   task automatic load_and_run(value_type qa[$], value_type qb[$]);
      int ia;
      int ib;
      ia = 0;
      ib = 0;
      while (ia < qa.size() || ib < qb.size()) begin
         if ($urandom_range(0, 15) == 0) send_item(OP_NONE, value_type'($urandom));
         if (ib >= qb.size() || (ia < qa.size() && $urandom_range(0, 1) == 0)) begin
            send_item(OP_LOAD_A, qa[ia]);
            ia++;
         end else begin
            send_item(OP_LOAD_B, qb[ib]);
            ib++;
         end
      end
      send_item(OP_RUN, value_type'($urandom));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.match_queue.size() != 0) @(posedge clock);
   endtask

   function automatic value_type pick_value(int mode);
      value_type pool [7];
      pool = '{VALUE_MIN, VALUE_MIN + 1, -1, 0, 1, VALUE_MAX - 1, VALUE_MAX};
      case (mode)
         0: return value_type'(int'($urandom_range(0, 16)) - 8);
         1: return value_type'($urandom);
         default: return pool[$urandom_range(0, 6)];
      endcase
   endfunction

   initial begin
      value_type qa [$];
      value_type qb [$];
      int        target;
      int        set_count;
      int        kind;
      int        mode;
      int        na;
      int        nb;
      int        k;
      int        guard;
      value_type hold;

      sb = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      qa = {};
      qb = {};
      load_and_run(qa, qb);
      qa = '{VALUE_MIN, -1, 0, 7, VALUE_MAX};
      qb = '{VALUE_MIN, 0, 0, VALUE_MAX};
      load_and_run(qa, qb);
      send_item(OP_NONE, -1);
      qa = '{5, 5, 5};
      qb = '{5, 5};
      load_and_run(qa, qb);
      qa = '{3, 1};
      qb = '{1};
      load_and_run(qa, qb);
      qa = '{4};
      qb = {};
      load_and_run(qa, qb);
      wait_drained();

      target = items_sent + RANDOM_ITEMS;
      set_count = 0;
      while (items_sent < target) begin
         idle_on = (items_sent < target - QUIET_ITEMS);
         kind = $urandom_range(0, 9);
         mode = $urandom_range(0, 2);
         na = $urandom_range(0, 8);
         nb = $urandom_range(0, 8);
         qa = {};
         qb = {};
         if (set_count == 1) begin
            for (k = 0; k < LIST_DEPTH + 1; k++) qa = {qa, pick_value(mode)};
            qa.sort();
            qb = qa;
            qb = {qb, pick_value(1)};
            load_and_run(qa, qb);
         end else if (kind == 0) begin
            for (k = $urandom_range(3, 8); k > 0; k--)
               send_item(op_type'($urandom_range(0, 3)), pick_value(mode));
         end else begin
            for (k = 0; k < na; k++) qa = {qa, pick_value(mode)};
            for (k = 0; k < nb; k++) begin
               if (na != 0 && $urandom_range(0, 1) == 0) qb = {qb, qa[$urandom_range(0, na - 1)]};
               else qb = {qb, pick_value(mode)};
            end
            if (kind == 1) begin
               for (k = 0; k + 1 < na; k++) begin
                  hold = qa[k];
                  qa[k] = qa[na - 1 - k];
                  qa[na - 1 - k] = hold;
               end
            end else begin
               qa.sort();
               qb.sort();
            end
            load_and_run(qa, qb);
         end
         if ($urandom_range(0, 5) == 0) wait_drained();
         set_count++;
      end
      send_item(OP_RUN, value_type'($urandom));

      @(negedge clock);
      req_valid <= 1'b0;
      guard = 0;
      while (sb.match_queue.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.match_queue.size() != 0)
         sb.report_mismatch($sformatf("%0d matches never arrived", sb.match_queue.size()));

      $display("Sent %0d load and run items over %0d runs, %0d of them with no common element.",
               items_sent, sb.runs, sb.empty_runs);
      $display("Checked %0d results; the longest run gave %0d matches.", sb.checked, sb.longest);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out waiting for the block.");
      $display("Verification failed");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/sli_pkg.sv
rtl/core/sli_list_mem.sv
rtl/core/sli_ctrl.sv
rtl/core/sorted_list_intersection.sv
tb/sv/sorted_list_intersection_tb.sv
